[sv/iee_pkg.sv]
package iee_pkg;

  localparam int StackDepth   = 64;
  localparam int PtrW         = $clog2(StackDepth);
  localparam int CntW         = PtrW + 1;
  localparam int FractionBits = 16;
  localparam int ValW         = 48;
  localparam int DivSteps     = ValW + FractionBits;

  typedef logic [2:0] mode_t;
  localparam mode_t ModeNum   = 3'd0;
  localparam mode_t ModeOp    = 3'd1;
  localparam mode_t ModeLeft  = 3'd2;
  localparam mode_t ModeRight = 3'd3;
  localparam mode_t ModeEnd   = 3'd4;

  typedef logic [1:0] opc_t;
  localparam opc_t OpAdd = 2'd0;
  localparam opc_t OpSub = 2'd1;
  localparam opc_t OpMul = 2'd2;
  localparam opc_t OpDiv = 2'd3;

  localparam logic [2:0] ParenCode = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t StOk       = 2'd0;
  localparam status_t StDivZero  = 2'd1;
  localparam status_t StOverflow = 2'd2;
  localparam status_t StMalformed = 2'd3;

  typedef enum logic [3:0] {
    CmdNone, CmdPushVal, CmdPushOp, CmdPopOp, CmdLoadTop,
    CmdStartArith, CmdWriteBack, CmdSetErr, CmdClear, CmdLatchResult
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [2:0] op_code;
    status_t    err;
  } cmd_t;

  typedef struct packed {
    logic [CntW-1:0] op_count;
    logic [CntW-1:0] val_count;
    logic [2:0]      top_op;
    status_t         err;
    logic            arith_done;
    logic            divisor_zero;
  } stat_t;

  function automatic logic [1:0] prec(input logic [2:0] op);
    if (op < 3'd2) return 2'd1;
    if (op < 3'd4) return 2'd2;
    return 2'd0;
  endfunction

endpackage

[sv/iee_datapath.sv]
module iee_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  iee_pkg::cmd_t        cmd,
  input  logic                 in_take,
  input  logic [47:0]          in_value,
  output iee_pkg::stat_t       stat,
  output logic [47:0]          result
);
  import iee_pkg::*;

  logic [2:0]      op_mem [StackDepth];
  logic [ValW-1:0] val_mem [StackDepth];
  logic [CntW-1:0] op_count, val_count;
  status_t         err;
  logic [2:0]      top_op;
  logic [ValW-1:0] tok_value;
  logic [ValW-1:0] x, y;
  logic [2:0]      aop;
  logic            busy, done, neg;
  logic [ValW-1:0] ua, ub;
  // multiply: partial products on 24-bit halves, summed into prod
  logic [95:0]     prod;
  logic [1:0]      mstep;
  // divide: restoring, one bit a cycle
  logic [DivSteps-1:0] dq;
  logic [ValW:0]       rem;
  logic [6:0]          dstep;
  logic [ValW-1:0]     rv;
  logic [ValW:0]       rem_sh, rem_sub;
  logic [95:0]         mshift;
  logic [ValW:0]       sum;

  assign stat.op_count = op_count;
  assign stat.val_count = val_count;
  assign stat.top_op = top_op;
  assign stat.err = err;
  assign stat.arith_done = done;
  assign stat.divisor_zero = (y == '0);

  assign rem_sh  = {rem[ValW-1:0], dq[DivSteps-1]};
  assign rem_sub = rem_sh - {1'b0, ub};
  assign mshift  = prod >> FractionBits;

  function automatic logic [ValW-1:0] sat(input logic n, input logic [95:0] m);
    if (n) begin
      if (m > 96'h800000000000) return {1'b1, {(ValW-1){1'b0}}};
      return ValW'(-m);
    end
    if (m > 96'h7FFFFFFFFFFF) return {1'b0, {(ValW-1){1'b1}}};
    return m[ValW-1:0];
  endfunction

  always_comb begin
    sum = (aop == {1'b0, OpAdd}) ? {x[ValW-1], x} + {y[ValW-1], y}
                                 : {x[ValW-1], x} - {y[ValW-1], y};
    if (sum[ValW] != sum[ValW-1]) rv = sum[ValW] ? {1'b1, {(ValW-1){1'b0}}}
                                                 : {1'b0, {(ValW-1){1'b1}}};
    else rv = sum[ValW-1:0];
  end

  // hold the number word from the accepting edge until it is pushed
  always_ff @(posedge clk) begin
    if (in_take) tok_value <= in_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_count <= '0;
      val_count <= '0;
      err <= StOk;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (cmd.kind)
        CmdPushVal: begin
          val_mem[val_count[PtrW-1:0]] <= tok_value;
          val_count <= val_count + 1'b1;
        end
        CmdPushOp: begin
          op_mem[op_count[PtrW-1:0]] <= cmd.op_code;
          op_count <= op_count + 1'b1;
        end
        CmdPopOp: op_count <= op_count - 1'b1;
        CmdLoadTop: begin
          y <= val_mem[PtrW'(val_count - 1'b1)];
          x <= val_mem[PtrW'(val_count - 2'd2)];
          aop <= top_op;
        end
        CmdStartArith: begin
          busy <= aop[1];
          done <= ~aop[1];
          neg <= x[ValW-1] ^ y[ValW-1];
          ua <= x[ValW-1] ? -x : x;
          ub <= y[ValW-1] ? -y : y;
          prod <= '0;
          mstep <= '0;
          rem <= '0;
          dstep <= '0;
          dq <= {(x[ValW-1] ? -x : x), {FractionBits{1'b0}}};
        end
        CmdWriteBack: begin
          if (aop[1] == 1'b0) val_mem[PtrW'(val_count - 2'd2)] <= rv;
          else if (aop[0] == 1'b0) val_mem[PtrW'(val_count - 2'd2)] <= sat(neg, mshift);
          else val_mem[PtrW'(val_count - 2'd2)] <= sat(neg, {32'd0, dq});
          val_count <= val_count - 1'b1;
        end
        CmdSetErr: if (err == StOk) err <= cmd.err;
        CmdClear: begin
          op_count <= '0;
          val_count <= '0;
          err <= StOk;
        end
        CmdLatchResult: result <= val_mem[0];
        default: ;
      endcase
      if (busy) begin
        if (aop[0] == 1'b0) begin
          unique case (mstep)
            2'd0: prod <= prod + ((96'(ua[23:0]) * 96'(ub[23:0])));
            2'd1: prod <= prod + ((96'(ua[47:24]) * 96'(ub[23:0])) << 24)
                               + ((96'(ua[23:0]) * 96'(ub[47:24])) << 24);
            default: prod <= prod + ((96'(ua[47:24]) * 96'(ub[47:24])) << 48);
          endcase
          mstep <= mstep + 1'b1;
          if (mstep == 2'd2) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end else begin
          if (!rem_sub[ValW]) begin
            rem <= rem_sub;
            dq <= {dq[DivSteps-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            dq <= {dq[DivSteps-2:0], 1'b0};
          end
          dstep <= dstep + 1'b1;
          if (dstep == 7'(DivSteps - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    top_op <= op_mem[PtrW'(op_count - 1'b1)];
    if (cmd.kind == CmdPushOp) top_op <= cmd.op_code;
    else if (cmd.kind == CmdPopOp) top_op <= op_mem[PtrW'(op_count - 2'd2)];
  end

endmodule

[sv/iee_ctrl.sv]
module iee_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          mode,
  input  logic [1:0]          operator_code,
  output logic                out_valid,
  input  logic                out_ready,
  output iee_pkg::status_t    out_status,
  input  iee_pkg::stat_t      stat,
  output iee_pkg::cmd_t       cmd
);
  import iee_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SSettle, SDecide, SLoad, SStart, SWait, SWrite, SEndChk, SLatch, SOut
  } state_t;

  state_t state;
  mode_t  tok_mode;
  opc_t   tok_op;
  logic   red_div;
  logic   full_op, full_val;

  // hold off the next word until the last command has reached the datapath
  assign in_ready = (state == SIdle) && !out_valid && (cmd.kind == CmdNone);
  assign full_op  = stat.op_count >= CntW'(StackDepth);
  assign full_val = stat.val_count >= CntW'(StackDepth);

  function automatic cmd_t mk(input cmd_kind_t k, input logic [2:0] o, input status_t e);
    cmd_t c;
    c.kind = k;
    c.op_code = o;
    c.err = e;
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
      cmd <= mk(CmdNone, 3'd0, StOk);
    end else begin
      cmd <= mk(CmdNone, 3'd0, StOk);
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        SIdle: if (in_valid && in_ready) begin
          tok_mode <= mode;
          tok_op <= operator_code;
          if (mode == ModeEnd) state <= SSettle;
          else if (stat.err != StOk || mode > ModeEnd) state <= SIdle;
          else if (mode == ModeNum) begin
            if (full_val) cmd <= mk(CmdSetErr, 3'd0, StOverflow);
            else cmd <= mk(CmdPushVal, 3'd0, StOk);
          end else state <= SSettle;
        end
        // wait for the top-of-stack register after any push or pop
        SSettle: state <= SDecide;
        SDecide: begin
          state <= SSettle;
          if (stat.err != StOk) begin
            state <= (tok_mode == ModeEnd) ? SEndChk : SIdle;
          end else if (tok_mode == ModeLeft) begin
            if (full_op) cmd <= mk(CmdSetErr, 3'd0, StOverflow);
            else cmd <= mk(CmdPushOp, ParenCode, StOk);
            state <= SIdle;
          end else if (stat.op_count == '0) begin
            if (tok_mode == ModeOp) begin
              if (full_op) cmd <= mk(CmdSetErr, 3'd0, StOverflow);
              else cmd <= mk(CmdPushOp, {1'b0, tok_op}, StOk);
              state <= SIdle;
            end else if (tok_mode == ModeRight) begin
              cmd <= mk(CmdSetErr, 3'd0, StMalformed);
              state <= SIdle;
            end else state <= SEndChk;
          end else if (stat.top_op == ParenCode) begin
            if (tok_mode == ModeOp) begin
              if (full_op) cmd <= mk(CmdSetErr, 3'd0, StOverflow);
              else cmd <= mk(CmdPushOp, {1'b0, tok_op}, StOk);
              state <= SIdle;
            end else if (tok_mode == ModeRight) begin
              cmd <= mk(CmdPopOp, 3'd0, StOk);
              state <= SIdle;
            end else begin
              cmd <= mk(CmdSetErr, 3'd0, StMalformed);
              state <= SEndChk;
            end
          end else if (tok_mode == ModeOp &&
                       prec(stat.top_op) < prec({1'b0, tok_op})) begin
            if (full_op) cmd <= mk(CmdSetErr, 3'd0, StOverflow);
            else cmd <= mk(CmdPushOp, {1'b0, tok_op}, StOk);
            state <= SIdle;
          end else begin
            // reduce the top operator
            if (stat.val_count < CntW'(2)) begin
              cmd <= mk(CmdPopOp, 3'd0, StOk);
              state <= SWait;
            end else begin
              cmd <= mk(CmdLoadTop, 3'd0, StOk);
              red_div <= (stat.top_op == {1'b0, OpDiv});
              state <= SLoad;
            end
          end
        end
        // operands and operator are captured, now drop the operator
        SLoad: begin
          cmd <= mk(CmdPopOp, 3'd0, StOk);
          state <= SStart;
        end
        SStart: begin
          if (red_div && stat.divisor_zero) begin
            cmd <= mk(CmdSetErr, 3'd0, StDivZero);
            state <= SSettle;
          end else begin
            cmd <= mk(CmdStartArith, 3'd0, StOk);
            state <= SWrite;
          end
        end
        SWrite: begin
          if (stat.arith_done) begin
            cmd <= mk(CmdWriteBack, 3'd0, StOk);
            state <= SSettle;
          end
        end
        SWait: begin
          cmd <= mk(CmdSetErr, 3'd0, StMalformed);
          state <= SSettle;
        end
        SEndChk: begin
          if (stat.err == StOk && stat.val_count != CntW'(1))
            cmd <= mk(CmdSetErr, 3'd0, StMalformed);
          state <= SLatch;
        end
        SLatch: begin
          cmd <= mk(CmdLatchResult, 3'd0, StOk);
          state <= SOut;
        end
        SOut: begin
          out_status <= stat.err;
          out_valid <= 1'b1;
          cmd <= mk(CmdClear, 3'd0, StOk);
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end

endmodule

[sv/infix_expression_evaluator_unit.sv]
// a number token is pushed without a reduction; an operator or paren token is settled and decided,
// plus one reduction per operator popped; multiply and divide run iterative datapath steps
// end token: the reductions run, then the result is valid and held until taken
// throughput: one token at a time, the next is taken once the previous has finished
// reset: synchronous, empties both stacks and clears the status
module infix_expression_evaluator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [1:0]         operator_code,
  input  logic signed [47:0] number_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] result_value,
  output logic [1:0]         status
);
  import iee_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  status_t st;
  logic [47:0] res;

  iee_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .operator_code(operator_code), .out_valid(out_valid),
    .out_ready(out_ready), .out_status(st), .stat(stat), .cmd(cmd)
  );

  iee_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_take(in_valid && in_ready),
    .in_value(number_value), .stat(stat), .result(res)
  );

  assign status = st;
  assign result_value = (st == StOk) ? res : '0;

endmodule
